### sv/remote_frame_parser_with_staleness_assert.svh
// Assertion macros shared by the remote frame parser modules.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef REMOTE_FRAME_PARSER_WITH_STALENESS_ASSERT_SVH
`define REMOTE_FRAME_PARSER_WITH_STALENESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rfps_pkg.sv
// ----------------------------------------------------------------------------
// rfps_pkg
// Types and constants of the remote frame parser with staleness check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfps_pkg;

  localparam int ByteW    = 8;
  localparam int KeyW     = 3;
  localparam int AnalogW  = 16;
  localparam int LimitW   = 8;
  localparam int FramesW  = 32;

  localparam logic [ByteW-1:0]  HdrByte      = 8'hff;
  localparam logic [ByteW-1:0]  Trail0Byte   = 8'ha5;
  localparam logic [ByteW-1:0]  Trail1Byte   = 8'h5a;
  localparam logic [ByteW-1:0]  KeyMask      = 8'h07;
  localparam logic [LimitW-1:0] UnchangedMax = 8'd200;
  localparam logic [LimitW-1:0] StaleReset   = 8'd30;

  localparam logic ReqByte = 1'b0;
  localparam logic ReqPoll = 1'b1;

  typedef enum logic [7:0] {
    PhHead = 8'b0000_0001,
    PhKey  = 8'b0000_0010,
    PhA1Lo = 8'b0000_0100,
    PhA1Hi = 8'b0000_1000,
    PhA2Lo = 8'b0001_0000,
    PhA2Hi = 8'b0010_0000,
    PhTr0  = 8'b0100_0000,
    PhTr1  = 8'b1000_0000
  } rfps_phase_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [AnalogW-1:0] analog_one;
    logic [AnalogW-1:0] analog_two;
  } rfps_frame_t;

endpackage

### sv/rfps_parser.sv
// ----------------------------------------------------------------------------
// rfps_parser
// Byte-driven frame parser that latches key and analog data of each frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfps_parser import rfps_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   byte_vld_i,
  input  logic [ByteW-1:0]       byte_i,
  output rfps_frame_t            frame_o,
  output logic [COUNT_WIDTH-1:0] frame_cnt_o
);

`include "remote_frame_parser_with_staleness_assert.svh"

  rfps_phase_e            phase_q, phase_d;
  rfps_frame_t            pend_q, pend_d;
  rfps_frame_t            latch_q, latch_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   done;

  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    latch_d = latch_q;
    cnt_d   = cnt_q;
    done    = 1'b0;
    if (byte_vld_i) begin
      case (phase_q)
        PhHead: phase_d = (byte_i == HdrByte) ? PhKey : PhHead;
        PhKey: begin
          if ((byte_i & ~KeyMask) != '0) begin
            phase_d = PhHead;
          end else begin
            pend_d.key = byte_i[KeyW-1:0];
            phase_d    = PhA1Lo;
          end
        end
        PhA1Lo: begin
          pend_d.analog_one = {8'h00, byte_i};
          phase_d           = PhA1Hi;
        end
        PhA1Hi: begin
          pend_d.analog_one[AnalogW-1:ByteW] = byte_i;
          phase_d                            = PhA2Lo;
        end
        PhA2Lo: begin
          pend_d.analog_two = {8'h00, byte_i};
          phase_d           = PhA2Hi;
        end
        PhA2Hi: begin
          pend_d.analog_two[AnalogW-1:ByteW] = byte_i;
          phase_d                            = PhTr0;
        end
        PhTr0: phase_d = (byte_i == Trail0Byte) ? PhTr1 : PhHead;
        PhTr1: begin
          if (byte_i == Trail1Byte) begin
            done    = 1'b1;
            latch_d = pend_q;
            cnt_d   = cnt_q + COUNT_WIDTH'(1);
          end
          phase_d = PhHead;
        end
        default: phase_d = PhHead;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHead;
      pend_q  <= '0;
      latch_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      latch_q <= latch_d;
      cnt_q   <= cnt_d;
    end
  end

  assign frame_o     = latch_q;
  assign frame_cnt_o = cnt_q;

  `RFPS_ASSERT_NEXT(a_cnt_step, done, cnt_q == $past(cnt_q) + COUNT_WIDTH'(1),
                    "Frame counter did not advance after a complete frame.")

endmodule

### sv/rfps_poll.sv
// ----------------------------------------------------------------------------
// rfps_poll
// Staleness tracking on polls and the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfps_poll import rfps_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   poll_i,
  input  rfps_frame_t            frame_i,
  input  logic [COUNT_WIDTH-1:0] frame_cnt_i,
  input  logic [LimitW-1:0]      stale_limit_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic                   data_ok_o,
  output rfps_frame_t            frame_o,
  output logic [FramesW-1:0]     frames_seen_o
);

`include "remote_frame_parser_with_staleness_assert.svh"

  localparam int ExtW = (COUNT_WIDTH > FramesW) ? COUNT_WIDTH : FramesW;

  logic [COUNT_WIDTH-1:0] last_q, last_d;
  logic [LimitW-1:0]      unch_q, unch_d;
  logic                   first_q, first_d;
  logic                   vld_q, vld_d;
  logic                   ok_q, ok_d;
  rfps_frame_t            res_q;
  logic [FramesW-1:0]     seen_q;
  logic [ExtW-1:0]        cnt_ext;
  logic                   last_nz;

  assign last_nz = (last_q != '0);
  assign cnt_ext = ExtW'(frame_cnt_i);

  always_comb begin
    last_d  = last_q;
    unch_d  = unch_q;
    first_d = first_q;
    if (poll_i) begin
      if (last_nz && (last_q == frame_cnt_i)) begin
        if (unch_q < UnchangedMax) begin
          unch_d = unch_q + 8'd1;
        end
      end else begin
        unch_d = '0;
      end
      if (last_nz) begin
        first_d = 1'b0;
      end
      last_d = frame_cnt_i;
    end
    ok_d = !first_d && (unch_d <= stale_limit_i);
    vld_d = poll_i | (vld_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      unch_q  <= '0;
      first_q <= 1'b1;
      vld_q   <= 1'b0;
    end else begin
      last_q  <= last_d;
      unch_q  <= unch_d;
      first_q <= first_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i) begin
      ok_q   <= ok_d;
      res_q  <= frame_i;
      seen_q <= cnt_ext[FramesW-1:0];
    end
  end

  assign out_valid_o   = vld_q;
  assign data_ok_o     = ok_q;
  assign frame_o       = res_q;
  assign frames_seen_o = seen_q;

  `RFPS_ASSERT_IMPL(a_unch_sat, 1'b1, unch_q <= UnchangedMax,
                    "Unchanged-poll count exceeded its saturation value.")
  `RFPS_ASSERT_NEXT(a_poll_res, poll_i, vld_q,
                    "A poll did not leave a result in the output register.")
  `RFPS_ASSERT_IMPL(a_first_clr, $fell(first_q), $past(last_q) != '0,
                    "First-poll flag cleared without an earlier nonzero count.")

endmodule

### sv/remote_frame_parser_with_staleness.sv
// ----------------------------------------------------------------------------
// remote_frame_parser_with_staleness
// Remote control frame parser with a staleness check on polls.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  in      | in_valid_i / in_stall_o   | req_type_i, rx_byte_i
//  out     | out_valid_o / out_stall_i | data_ok_o, key*_pressed_o, analog_*_o,
//          |                           | frames_seen_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (stale limit)
//
// Transactions pass an input register, one taken per cycle unless the input
// stalls; a poll result enters the output register as the poll leaves the
// input register. A byte never waits on the output side. A poll waits in the
// input register while the output register holds an untaken result, and the
// input then stalls. Reset clears the parser, the latched frame data, the
// counters and sets the stale limit to 30; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module remote_frame_parser_with_staleness import rfps_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [ByteW-1:0]     rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 data_ok_o,
  output logic                 key1_pressed_o,
  output logic                 key2_pressed_o,
  output logic                 key3_pressed_o,
  output logic [AnalogW-1:0]   analog_one_o,
  output logic [AnalogW-1:0]   analog_two_o,
  output logic [FramesW-1:0]   frames_seen_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LimitW-1:0]    cfg_data_i
);

`include "remote_frame_parser_with_staleness_assert.svh"

  logic                   in_vld_q, in_vld_d;
  logic                   req_q;
  logic [ByteW-1:0]       byte_q;
  logic [LimitW-1:0]      limit_q;
  logic                   accept;
  logic                   advance;
  rfps_frame_t            frame;
  rfps_frame_t            res_frame;
  logic [COUNT_WIDTH-1:0] frame_cnt;

  assign advance    = in_vld_q && ((req_q == ReqByte) || !out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept | (in_vld_q & ~advance);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      limit_q  <= StaleReset;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      byte_q <= rx_byte_i;
    end
  end

  rfps_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (advance && (req_q == ReqByte)),
    .byte_i     (byte_q),
    .frame_o    (frame),
    .frame_cnt_o(frame_cnt)
  );

  rfps_poll #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_poll (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .poll_i       (advance && (req_q == ReqPoll)),
    .frame_i      (frame),
    .frame_cnt_i  (frame_cnt),
    .stale_limit_i(limit_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .data_ok_o    (data_ok_o),
    .frame_o      (res_frame),
    .frames_seen_o(frames_seen_o)
  );

  assign key1_pressed_o = res_frame.key[0];
  assign key2_pressed_o = res_frame.key[1];
  assign key3_pressed_o = res_frame.key[2];
  assign analog_one_o   = res_frame.analog_one;
  assign analog_two_o   = res_frame.analog_two;

  `RFPS_ASSERT_NEXT(a_hold_in, in_stall_o, in_vld_q,
                    "Held transaction was dropped from the input register.")

endmodule
